### sv/polygon_point_inside_test_unit_assert.svh
// Assertion macros shared by the polygon point test checker.
`ifndef POLYGON_POINT_INSIDE_TEST_UNIT_ASSERT_SVH
`define POLYGON_POINT_INSIDE_TEST_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PPIT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ppit assertion failed");

// Next-cycle implication, disabled during reset.
`define PPIT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ppit assertion failed");

`endif

### sv/ppit_pkg.sv
// Types and constants for the polygon point test unit.
`timescale 1ns / 1ps
package ppit_pkg;

   localparam int MAX_VERTICES_DEF = 16;
   localparam int COORD_BITS_DEF   = 16;
   localparam int COORD_CAP        = 30;
   localparam int MIN_POLY         = 3;
   localparam int FIELD_BITS       = 16;
   localparam int INDEX_BITS       = 4;
   localparam int COUNT_BITS       = 5;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_REMOVE = 2'd1,
      OP_TEST   = 2'd2
   } op_type;

   typedef struct packed {
      op_type                        op;
      logic signed [FIELD_BITS-1:0]  coord_x;
      logic signed [FIELD_BITS-1:0]  coord_y;
      logic [INDEX_BITS-1:0]         remove_index;
   } req_type;

   typedef struct packed {
      logic                  accepted;
      logic                  inside_res;
      logic                  convex;
      logic [COUNT_BITS-1:0] count_now;
   } rsp_type;

   // Per-cell load selection.
   typedef struct packed {
      logic take_in;
      logic take_next;
      logic take_wrap;
   } cell_cmd_type;

   // Control of the geometry pipeline.
   typedef struct packed {
      logic clear;
      logic valid;
      logic first;
   } geom_cmd_type;

   // Results collected by the geometry pipeline.
   typedef struct packed {
      logic convex_ok;
      logic inside_hit;
   } geom_stat_type;

endpackage

### sv/polygon_point_inside_test_unit.sv
// Top level of the polygon point test unit: vertex ring, sequencer and result register.
`timescale 1ns / 1ps
// The polygon is held in a ring of vertex cells. Append and remove edit the ring
// in the edit state; with at least three vertices left, the item then rotates the
// ring once around, one vertex a cycle, feeding a three-stage cross and dot product
// unit that checks convexity and, for a point test, edges and winding; the pipeline
// then drains. busy is high from acceptance until the result is shown; the result is
// shown for one cycle with rsp_valid, and the receiver cannot stall it. A new item
// may be started in the cycle the result is shown.
module polygon_point_inside_test_unit import ppit_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int COORD_BITS   = COORD_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int CW   = (COORD_BITS < COORD_CAP) ? COORD_BITS : COORD_CAP;
   localparam int CNTW = $clog2(MAX_VERTICES + 1);
   localparam int XW   = CNTW + INDEX_BITS;

   typedef enum logic [1:0] {S_IDLE, S_EDIT, S_WALK, S_DRAIN} state_type;

   state_type        state_ff;
   req_type          req_ff;
   logic [CNTW-1:0]  count_ff, count_in, step_ff;
   logic [1:0]       drain_ff;
   logic             acc_ff, acc_in;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   logic signed [CW-1:0] qx, qy;
   logic signed [CW-1:0] cx [MAX_VERTICES];
   logic signed [CW-1:0] cy [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] match, live;
   logic             dup, append_ok, rm_ok, edit, walk;
   logic [XW-1:0]    idx_x, cnt_x;
   geom_cmd_type     gcmd;
   geom_stat_type    gstat;

   // Coordinates as stored in the cells.
   if (CW <= FIELD_BITS) begin : g_narrow
      assign qx = req_ff.coord_x[CW-1:0];
      assign qy = req_ff.coord_y[CW-1:0];
   end else begin : g_wide
      assign qx = CW'(req_ff.coord_x);
      assign qy = CW'(req_ff.coord_y);
   end

   assign edit  = (state_ff == S_EDIT);
   assign walk  = (state_ff == S_WALK);
   assign idx_x = XW'(req_ff.remove_index);
   assign cnt_x = XW'(count_ff);

   // Vertex ring.
   for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
      cell_cmd_type         ccmd;
      logic signed [CW-1:0] nx, ny;

      assign live[k] = XW'(k) < cnt_x;
      assign ccmd.take_in = edit && (req_ff.op == OP_APPEND) && append_ok
                            && (cnt_x == XW'(k));
      assign ccmd.take_next = (edit && (req_ff.op == OP_REMOVE) && rm_ok
                               && (XW'(k) >= idx_x) && (XW'(k + 1) < cnt_x))
                              || (walk && (XW'(k + 1) < cnt_x));
      assign ccmd.take_wrap = walk && (XW'(k + 1) == cnt_x);

      if (k < MAX_VERTICES - 1) begin : g_mid
         assign nx = cx[k + 1];
         assign ny = cy[k + 1];
      end else begin : g_last
         assign nx = cx[0];
         assign ny = cy[0];
      end

      ppit_cell #(.CW(CW)) u_cell (
         .clock  (clock),
         .cmd    (ccmd),
         .next_x (nx),
         .next_y (ny),
         .wrap_x (cx[0]),
         .wrap_y (cy[0]),
         .in_x   (qx),
         .in_y   (qy),
         .x      (cx[k]),
         .y      (cy[k]),
         .match  (match[k])
      );
   end

   // Edit decisions.
   assign dup       = |(match & live);
   assign append_ok = !dup && (count_ff < CNTW'(MAX_VERTICES));
   assign rm_ok     = idx_x < cnt_x;

   always_comb begin
      count_in = count_ff;
      acc_in   = 1'b0;
      unique case (req_ff.op)
         OP_APPEND: begin
            if (append_ok) begin
               count_in = count_ff + CNTW'(1);
               acc_in   = 1'b1;
            end
         end
         OP_REMOVE: begin
            if (rm_ok) begin
               count_in = count_ff - CNTW'(1);
               acc_in   = 1'b1;
            end
         end
         OP_TEST: begin
            acc_in = 1'b1;
         end
         default: begin
            acc_in = 1'b0;
         end
      endcase
   end

   // Geometry pipeline.
   assign gcmd.clear = edit;
   assign gcmd.valid = walk;
   assign gcmd.first = (step_ff == '0);

   ppit_geom #(.CW(CW), .MAXV(MAX_VERTICES)) u_geom (
      .clock (clock),
      .reset (reset),
      .cmd   (gcmd),
      .v0x   (cx[0]),
      .v0y   (cy[0]),
      .v1x   (cx[1]),
      .v1y   (cy[1]),
      .v2x   (cx[2]),
      .v2y   (cy[2]),
      .px    (qx),
      .py    (qy),
      .stat  (gstat)
   );

   // Sequencer and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         drain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff   <= req_data;
                  state_ff <= S_EDIT;
               end
            end
            S_EDIT: begin
               count_ff <= count_in;
               acc_ff   <= acc_in;
               step_ff  <= '0;
               drain_ff <= '0;
               state_ff <= (count_in >= CNTW'(MIN_POLY)) ? S_WALK : S_DRAIN;
            end
            S_WALK: begin
               step_ff <= step_ff + CNTW'(1);
               if (step_ff == count_ff - CNTW'(1)) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               drain_ff <= drain_ff + 2'd1;
               if (drain_ff == 2'd2) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_ff.accepted     <= acc_ff;
                  rsp_ff.inside_res   <= (req_ff.op == OP_TEST)
                                         && (count_ff >= CNTW'(MIN_POLY))
                                         && gstat.inside_hit;
                  rsp_ff.convex       <= (count_ff >= CNTW'(MIN_POLY)) && gstat.convex_ok;
                  rsp_ff.count_now    <= COUNT_BITS'(count_ff);
                  state_ff            <= S_IDLE;
               end
            end
         endcase
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### sv/ppit_cell.sv
// One vertex cell of the polygon ring.
`timescale 1ns / 1ps
module ppit_cell import ppit_pkg::*; #(
   parameter int CW = COORD_BITS_DEF
) (
   input  logic                 clock,
   input  cell_cmd_type         cmd,
   input  logic signed [CW-1:0] next_x,
   input  logic signed [CW-1:0] next_y,
   input  logic signed [CW-1:0] wrap_x,
   input  logic signed [CW-1:0] wrap_y,
   input  logic signed [CW-1:0] in_x,
   input  logic signed [CW-1:0] in_y,
   output logic signed [CW-1:0] x,
   output logic signed [CW-1:0] y,
   output logic                 match
);

   logic signed [CW-1:0] x_ff;
   logic signed [CW-1:0] y_ff;

   // Load a new vertex, take the neighbor's, or close the ring.
   always_ff @(posedge clock) begin
      priority if (cmd.take_in) begin
         x_ff <= in_x;
         y_ff <= in_y;
      end else if (cmd.take_next) begin
         x_ff <= next_x;
         y_ff <= next_y;
      end else if (cmd.take_wrap) begin
         x_ff <= wrap_x;
         y_ff <= wrap_y;
      end else begin
         x_ff <= x_ff;
         y_ff <= y_ff;
      end
   end

   // Equality with the incoming vertex for the duplicate check.
   assign match = (x_ff == in_x) && (y_ff == in_y);
   assign x = x_ff;
   assign y = y_ff;

endmodule

### sv/ppit_geom.sv
// Three-stage cross and dot product unit with convexity and winding accumulation.
`timescale 1ns / 1ps
module ppit_geom import ppit_pkg::*; #(
   parameter int CW   = COORD_BITS_DEF,
   parameter int MAXV = MAX_VERTICES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  geom_cmd_type         cmd,
   input  logic signed [CW-1:0] v0x,
   input  logic signed [CW-1:0] v0y,
   input  logic signed [CW-1:0] v1x,
   input  logic signed [CW-1:0] v1y,
   input  logic signed [CW-1:0] v2x,
   input  logic signed [CW-1:0] v2y,
   input  logic signed [CW-1:0] px,
   input  logic signed [CW-1:0] py,
   output geom_stat_type        stat
);

   localparam int DW = CW + 1;
   localparam int PW = 2 * DW;
   localparam int SW = PW + 1;
   localparam int WW = $clog2(MAXV + 1) + 1;

   logic signed [DW-1:0] d1x_ff, d1y_ff, d2x_ff, d2y_ff;
   logic signed [DW-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic                 va_ff, fa_ff;
   logic signed [PW-1:0] c1_ff, c2_ff, p1_ff, p2_ff, q1_ff, q2_ff;
   logic                 up_ff, down_ff, vb_ff, fb_ff;
   logic signed [SW-1:0] turn, cr, dt;
   logic                 left_ff, conv_ok_ff, onedge_ff;
   logic signed [WW-1:0] wind_ff, wind_or;

   // Stage one: edge vectors and offsets from the query point.
   always_ff @(posedge clock) begin
      d1x_ff <= DW'(v1x) - DW'(v0x);
      d1y_ff <= DW'(v1y) - DW'(v0y);
      d2x_ff <= DW'(v2x) - DW'(v1x);
      d2y_ff <= DW'(v2y) - DW'(v1y);
      ax_ff  <= DW'(v0x) - DW'(px);
      ay_ff  <= DW'(v0y) - DW'(py);
      bx_ff  <= DW'(v1x) - DW'(px);
      by_ff  <= DW'(v1y) - DW'(py);
      fa_ff  <= cmd.first;
   end

   // Stage two: products and crossing direction.
   always_ff @(posedge clock) begin
      c1_ff   <= PW'(d1x_ff) * PW'(d2y_ff);
      c2_ff   <= PW'(d1y_ff) * PW'(d2x_ff);
      p1_ff   <= PW'(ax_ff) * PW'(by_ff);
      p2_ff   <= PW'(ay_ff) * PW'(bx_ff);
      q1_ff   <= PW'(ax_ff) * PW'(bx_ff);
      q2_ff   <= PW'(ay_ff) * PW'(by_ff);
      up_ff   <= ay_ff[DW-1] && !by_ff[DW-1];
      down_ff <= by_ff[DW-1] && !ay_ff[DW-1];
      fb_ff   <= fa_ff;
   end

   // Stage valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= cmd.valid;
         vb_ff <= va_ff;
      end
   end

   assign turn = SW'(c1_ff) - SW'(c2_ff);
   assign cr   = SW'(p1_ff) - SW'(p2_ff);
   assign dt   = SW'(q1_ff) + SW'(q2_ff);

   // Stage three: orientation, convexity, edge hit and winding count.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         left_ff    <= 1'b0;
         conv_ok_ff <= 1'b1;
         onedge_ff  <= 1'b0;
         wind_ff    <= '0;
      end else if (vb_ff) begin
         if (fb_ff) begin
            left_ff <= (turn > 0);
         end else if ((left_ff && turn < 0) || (!left_ff && turn > 0)) begin
            conv_ok_ff <= 1'b0;
         end
         if (cr == 0 && dt <= 0) begin
            onedge_ff <= 1'b1;
         end
         if (up_ff && cr > 0) begin
            wind_ff <= wind_ff + WW'(1);
         end else if (down_ff && cr < 0) begin
            wind_ff <= wind_ff - WW'(1);
         end
      end
   end

   // The count is kept in counterclockwise sense and flipped for clockwise rings.
   assign wind_or = left_ff ? wind_ff : -wind_ff;
   assign stat.convex_ok  = conv_ok_ff;
   assign stat.inside_hit = onedge_ff || (wind_or > 0 && wind_or[0]);

endmodule

### sv/ppit_checker.sv
// Port-level checks of the polygon point test unit, bound to the top level.
`timescale 1ns / 1ps
`include "polygon_point_inside_test_unit_assert.svh"
module ppit_checker import ppit_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // A result only follows a busy period, and the unit is free when it shows.
   `PPIT_ASSERT_IMP(a_rsp_after_busy, clock, reset, rsp_valid, $past(busy))
   `PPIT_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid, !busy)
   // An accepted item makes the unit busy.
   `PPIT_ASSERT_NXT(a_start_busy, clock, reset, start && !busy, busy)
   // Only an accepted item reports inside.
   `PPIT_ASSERT_IMP(a_inside_acc, clock, reset, rsp_valid && rsp_data.inside_res, rsp_data.accepted)

endmodule

bind polygon_point_inside_test_unit ppit_checker u_ppit_checker (.*);

### tb/tb_top.sv
// Self-checking testbench for the polygon point test unit.
`timescale 1ns / 1ps
module tb_top;
   import ppit_pkg::*;

   localparam int NUM_RANDOM  = 1000;
   localparam int CYCLE_LIMIT = 400000;
   localparam int NVERT       = 16;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   // Shadow copy of the vertex table.
   longint  shadow_x [NVERT];
   longint  shadow_y [NVERT];
   int      shadow_count;

   rsp_type expected_rsp_q [$];
   int      error_count;
   int      cycle_count;
   int      sender_idle_pct;

   // Directed rows; has_fixed marks rows whose answer is typed in.
   typedef struct {
      req_type req;
      bit      has_fixed;
      rsp_type fixed;
   } dir_row_type;

   dir_row_type dir_rows [$];

   polygon_point_inside_test_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint turn_of(longint ax, longint ay, longint bx, longint by);
      return ax * by - ay * bx;
   endfunction

   // Turn at vertex b of the path a, b, c.
   function automatic longint corner_turn(int a, int b, int c);
      return turn_of(shadow_x[b] - shadow_x[a], shadow_y[b] - shadow_y[a],
                     shadow_x[c] - shadow_x[b], shadow_y[c] - shadow_y[b]);
   endfunction

   function automatic bit table_convex();
      bit     ccw;
      longint t;
      if (shadow_count < MIN_POLY) return 1'b0;
      ccw = corner_turn(0, 1, 2) > 0;
      for (int i = 1; i < shadow_count; i++) begin
         t = corner_turn(i, (i + 1) % shadow_count, (i + 2) % shadow_count);
         if (ccw && t < 0) return 1'b0;
         if (!ccw && t > 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic bit point_inside(longint px, longint py);
      bit     ccw;
      int     winding;
      int     j;
      longint ax, ay, bx, by, cr, dt;
      winding = 0;
      if (shadow_count < MIN_POLY) return 1'b0;
      ccw = corner_turn(0, 1, 2) > 0;
      for (int i = 0; i < shadow_count; i++) begin
         j  = (i + 1) % shadow_count;
         ax = shadow_x[i] - px;
         ay = shadow_y[i] - py;
         bx = shadow_x[j] - px;
         by = shadow_y[j] - py;
         cr = turn_of(ax, ay, bx, by);
         dt = ax * bx + ay * by;
         // A point on an edge counts as inside.
         if (cr == 0 && dt <= 0) return 1'b1;
         if (!ccw) begin
            if (ay < by) begin
               if (ay < 0 && by >= 0 && cr > 0) winding--;
            end else begin
               if (by < 0 && ay >= 0 && cr < 0) winding++;
            end
         end else begin
            if (ay > by) begin
               if (by < 0 && ay >= 0 && cr < 0) winding--;
            end else begin
               if (ay < 0 && by >= 0 && cr > 0) winding++;
            end
         end
      end
      return winding > 0 && (winding % 2) == 1;
   endfunction

   // Applies one item to the shadow table and returns the expected result.
   function automatic rsp_type polygon_predict(req_type req);
      rsp_type r;
      bit      dup;
      longint  px, py;
      int      idx;
      r   = '0;
      px  = req.coord_x;
      py  = req.coord_y;
      idx = req.remove_index;
      case (req.op)
         OP_APPEND: begin
            dup = 1'b0;
            for (int i = 0; i < shadow_count; i++)
               if (shadow_x[i] == px && shadow_y[i] == py) dup = 1'b1;
            if (!dup && shadow_count < NVERT) begin
               shadow_x[shadow_count] = px;
               shadow_y[shadow_count] = py;
               shadow_count++;
               r.accepted = 1'b1;
            end
         end
         OP_REMOVE: begin
            if (idx < shadow_count) begin
               for (int i = idx; i + 1 < shadow_count; i++) begin
                  shadow_x[i] = shadow_x[i + 1];
                  shadow_y[i] = shadow_y[i + 1];
               end
               shadow_count--;
               r.accepted = 1'b1;
            end
         end
         OP_TEST: begin
            r.accepted   = 1'b1;
            r.inside_res = point_inside(px, py);
         end
         default: ;
      endcase
      r.convex    = table_convex();
      r.count_now = shadow_count[COUNT_BITS-1:0];
      return r;
   endfunction

   function automatic req_type make_req(logic [1:0] op, int x, int y, int idx);
      req_type q;
      q.op           = op_type'(op);
      q.coord_x      = x[15:0];
      q.coord_y      = y[15:0];
      q.remove_index = idx[3:0];
      return q;
   endfunction

   function automatic rsp_type make_rsp(bit acc, bit ins, bit cvx, int cnt);
      rsp_type r;
      r.accepted   = acc;
      r.inside_res = ins;
      r.convex     = cvx;
      r.count_now  = cnt[COUNT_BITS-1:0];
      return r;
   endfunction

   task automatic add_row(req_type req, bit fixed_ok = 1'b0, rsp_type fixed = '0);
      dir_row_type row;
      row.req       = req;
      row.has_fixed = fixed_ok;
      row.fixed     = fixed;
      dir_rows.push_back(row);
   endtask

   // Drives one item at the falling edge and waits until it is taken.
   // start is lowered only while the sender idles, so it gets one update per edge.
   task automatic send_item(req_type req, bit has_fixed, rsp_type fixed);
      rsp_type pred;
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      req_data <= req;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      pred = polygon_predict(req);
      if (has_fixed && pred !== fixed)
         $error("directed row: typed %p, predicted %p", fixed, pred);
      expected_rsp_q.push_back(has_fixed ? fixed : pred);
      @(negedge clock);
   endtask

   // Random coordinate: a coarse grid half of the time, else the full range or an extreme.
   function automatic int rand_coord();
      case ($urandom_range(3))
         0:       return $urandom_range(65535) - 32768;
         1:       return ($urandom_range(1) ? 32767 : -32768);
         default: return (int'($urandom_range(16)) - 8) * 256;
      endcase
   endfunction

   task automatic send_random();
      int      pick;
      int      cnt;
      req_type q;
      cnt  = shadow_count;
      pick = $urandom_range(99);
      if (pick < 45 && cnt < 10)
         q = make_req(OP_APPEND, rand_coord(), rand_coord(), $urandom_range(15));
      else if (pick < 55)
         q = make_req(OP_APPEND, rand_coord(), rand_coord(), $urandom_range(15));
      else if (pick < 70)
         q = make_req(OP_REMOVE, rand_coord(), rand_coord(),
                      (cnt > 0 && $urandom_range(3) != 0) ? $urandom_range(cnt - 1)
                                                          : $urandom_range(15));
      else if (pick < 97)
         q = make_req(OP_TEST, rand_coord(), rand_coord(), $urandom_range(15));
      else
         q = make_req(2'd3, rand_coord(), rand_coord(), $urandom_range(15));
      send_item(q, 1'b0, '0);
   endtask

   // Result checker.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsp_q.size() == 0) begin
            $error("result with no item outstanding: %p", rsp_data);
            error_count++;
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_data.accepted !== want.accepted) begin
               $error("accepted: expected %0d, actual %0d", want.accepted, rsp_data.accepted);
               error_count++;
            end
            if (rsp_data.inside_res !== want.inside_res) begin
               $error("inside_res: expected %0d, actual %0d",
                      want.inside_res, rsp_data.inside_res);
               error_count++;
            end
            if (rsp_data.convex !== want.convex) begin
               $error("convex: expected %0d, actual %0d", want.convex, rsp_data.convex);
               error_count++;
            end
            if (rsp_data.count_now !== want.count_now) begin
               $error("count_now: expected %0d, actual %0d",
                      want.count_now, rsp_data.count_now);
               error_count++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      error_count     = 0;
      cycle_count     = 0;
      shadow_count    = 0;
      sender_idle_pct = 0;
      reset           = 1'b1;
      start           = 1'b0;
      req_data        = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table: empty table cases, a square, edges, a full table.
      add_row(make_req(OP_TEST, 0, 0, 0), 1'b1, make_rsp(1, 0, 0, 0));
      add_row(make_req(OP_REMOVE, 0, 0, 0), 1'b1, make_rsp(0, 0, 0, 0));
      add_row(make_req(2'd3, 32767, -32768, 15), 1'b1, make_rsp(0, 0, 0, 0));
      add_row(make_req(OP_APPEND, -32768, -32768, 15), 1'b1, make_rsp(1, 0, 0, 1));
      add_row(make_req(OP_APPEND, -32768, -32768, 0), 1'b1, make_rsp(0, 0, 0, 1));
      add_row(make_req(OP_APPEND, 32767, -32768, 0), 1'b1, make_rsp(1, 0, 0, 2));
      add_row(make_req(OP_TEST, 0, 0, 0), 1'b1, make_rsp(1, 0, 0, 2));
      add_row(make_req(OP_APPEND, 32767, 32767, 0));
      add_row(make_req(OP_APPEND, -32768, 32767, 0));
      add_row(make_req(OP_TEST, 0, 0, 0));
      add_row(make_req(OP_TEST, 32767, 0, 0));
      add_row(make_req(OP_TEST, -32768, -32768, 0));
      add_row(make_req(OP_REMOVE, 0, 0, 15), 1'b1, make_rsp(0, 0, 1, 4));
      add_row(make_req(OP_APPEND, 0, 0, 0));
      add_row(make_req(OP_TEST, 100, 200, 0));
      add_row(make_req(OP_REMOVE, 0, 0, 4));
      add_row(make_req(OP_REMOVE, 0, 0, 0));
      // The same square again, starting at another vertex.
      add_row(make_req(OP_APPEND, -32768, -32768, 0));
      add_row(make_req(OP_TEST, -5, 7, 0));
      for (int i = 0; i < 3; i++) begin
         foreach (dir_rows[k]) send_item(dir_rows[k].req, dir_rows[k].has_fixed,
                                         dir_rows[k].fixed);
         dir_rows.delete();
         if (i > 0) break;
         // Fill the table past full.
         for (int k = 0; k < 17; k++) add_row(make_req(OP_APPEND, k * 300, k * k * 40, 0));
         add_row(make_req(OP_TEST, 2000, 3000, 0));
         add_row(make_req(OP_REMOVE, 0, 0, 15));
      end

      // Random part in three idling phases.
      for (int ph = 0; ph < 3; ph++) begin
         sender_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 65 : 0;
         for (int n = 0; n < NUM_RANDOM / 3; n++) send_random();
      end
      start <= 1'b0;

      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
